// ----- rtl/pfba_pkg.sv -----
// ----------------------------------------------------------------------------
// Page frame bitmap allocator package
// Shared types, widths and codes for the allocator and its checker.
// ----------------------------------------------------------------------------
package pfba_pkg;

  // Default number of page frames held in the bitmap.
  localparam int unsigned NUM_FRAMES_DEF = 4096;

  // Fixed field widths.
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned STATUS_W = 2;

  // Reset value of the frame count register.
  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes.
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_EXHAUSTED = 2'd1;
  localparam status_t STATUS_BAD_FREE  = 2'd2;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Request and response payloads.
  typedef struct packed {
    logic               cmd;
    logic [INDEX_W-1:0] frame_index;
  } pfba_req_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] result_index;
  } pfba_rsp_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } pfba_state_e;

endpackage

// ----- rtl/page_frame_bitmap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Page frame bitmap allocator
// Next-fit allocator over a byte-wide bitmap of used page frames, with a
// free-frame count and a byte pointer, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Timing: a request is taken in ST_IDLE; each bitmap byte is read in ST_READ
// and checked in ST_CHECK, and the done strobe is registered. An allocate with
// no free frame answers in the next cycle. One request at a time: the single
// bitmap memory port reads and checks one byte at a time, so a full scan sets
// the worst case. Reset and every frame_count write run a clearing pass of one
// bitmap byte per cycle with busy high. Results cannot be stalled.
module page_frame_bitmap_allocator_unit #(
  parameter int unsigned NUM_FRAMES = pfba_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfba_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic                          start,
  input  pfba_pkg::pfba_req_t           req_i,
  output logic                          busy,
  output logic                          done_o,
  output pfba_pkg::pfba_rsp_t           rsp_o
);
  import pfba_pkg::*;

  // Sizes derived from the frame count and the count register width.
  localparam int unsigned BYTES     = (NUM_FRAMES + 7) / 8;
  localparam int unsigned CNT_BYTES = ((2 ** COUNT_W - 1) + 7) / 8;
  localparam int unsigned MAXB      = (BYTES > CNT_BYTES) ? CNT_BYTES : BYTES;
  localparam int unsigned PW        = (MAXB > 1) ? $clog2(MAXB) : 1;
  localparam int unsigned NB_W      = $clog2(MAXB + 1);
  localparam int unsigned CW1       = COUNT_W + 1;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (NUM_FRAMES >= 2 ** COUNT_W - 1) ? {COUNT_W{1'b1}} : COUNT_W'(NUM_FRAMES);
  localparam logic [PW-1:0] LAST_BYTE = PW'(MAXB - 1);

  // Usable frame count: the written count capped at the bitmap size.
  function automatic logic [COUNT_W-1:0] usable_of(input logic [COUNT_W-1:0] c);
    usable_of = (c > COUNT_CAP) ? COUNT_CAP : c;
  endfunction

  localparam logic [COUNT_W-1:0] USABLE_RST = usable_of(FRAME_COUNT_RST);

  // Registers.
  pfba_state_e         state_q, state_d;
  logic [COUNT_W-1:0]  usable_q, usable_d;
  logic [COUNT_W-1:0]  free_q, free_d;
  logic [PW-1:0]       search_q, search_d;
  logic [PW-1:0]       addr_q, addr_d;
  logic [NB_W-1:0]     scan_q, scan_d;
  logic                cmd_q, cmd_d;
  logic [INDEX_W-1:0]  idx_q, idx_d;
  logic                done_q, done_d;
  pfba_rsp_t           rsp_q, rsp_d;

  // Bitmap memory and its port.
  logic [7:0]          bitmap_q [MAXB];
  logic [7:0]          rdata_q;
  logic                mem_we;
  logic [7:0]          mem_wdata;

  // Datapath signals.
  logic [CW1-1:0]      nb_full;
  logic [NB_W-1:0]     nbytes;
  logic [PW-1:0]       start_byte;
  logic [PW-1:0]       next_byte;
  logic                scan_end;
  logic [15:0]         idx_ext;
  logic [CW1-1:0]      first_bit;
  logic [CW1-1:0]      left_bits;
  logic [7:0]          valid_mask;
  logic [7:0]          avail;
  logic [2:0]          bit_sel;
  logic                found;
  logic                free_oob;
  logic                free_ok;
  logic [7:0]          free_onehot;

  // Number of bitmap bytes in use and the scan start byte.
  always_comb begin
    nb_full    = (CW1'(usable_q) + CW1'(7)) >> 3;
    nbytes     = nb_full[NB_W-1:0];
    start_byte = (NB_W'(search_q) < nbytes) ? search_q : '0;
    next_byte  = ((NB_W'(addr_q) + NB_W'(1)) == nbytes) ? '0 : addr_q + PW'(1);
    scan_end   = (scan_q + NB_W'(1)) == nbytes;
    idx_ext    = 16'(req_i.frame_index);
  end

  // Usable bits of the current byte and the lowest free one.
  always_comb begin
    first_bit = CW1'({addr_q, 3'b000});
    left_bits = CW1'(usable_q) - first_bit;
    if (first_bit >= CW1'(usable_q)) begin
      valid_mask = 8'h00;
    end else if (left_bits >= CW1'(8)) begin
      valid_mask = 8'hFF;
    end else begin
      valid_mask = 8'((9'd1 << left_bits[2:0]) - 9'd1);
    end
    avail   = ~rdata_q & valid_mask;
    found   = |avail;
    bit_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (avail[i]) begin
        bit_sel = 3'(i);
      end
    end
  end

  // Free checks: index range and the frame's used bit.
  always_comb begin
    free_oob    = {1'b0, idx_q} >= usable_q;
    free_onehot = 8'h01 << idx_q[2:0];
    free_ok     = !free_oob && ((rdata_q & free_onehot) != 8'h00);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (addr_q == LAST_BYTE) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && !(req_i.cmd == CMD_ALLOC && (free_q == '0 || nbytes == '0))) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (cmd_q == CMD_FREE || found || scan_end) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end
  end

  // Datapath updates, memory writes and the result.
  always_comb begin
    usable_d  = usable_q;
    free_d    = free_q;
    search_d  = search_q;
    addr_d    = addr_q;
    scan_d    = scan_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_wdata = 8'h00;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        addr_d = (addr_q == LAST_BYTE) ? '0 : addr_q + PW'(1);
      end
      ST_IDLE: begin
        if (start) begin
          cmd_d = req_i.cmd;
          idx_d = req_i.frame_index;
          if (req_i.cmd == CMD_ALLOC) begin
            addr_d = start_byte;
            scan_d = '0;
            if (free_q == '0 || nbytes == '0) begin
              done_d = 1'b1;
              rsp_d  = '{status: STATUS_EXHAUSTED, result_index: '0};
            end
          end else begin
            addr_d = idx_ext[PW+2:3];
          end
        end
      end
      ST_READ: begin
        // Memory read of addr_q is in flight.
      end
      ST_CHECK: begin
        if (cmd_q == CMD_FREE) begin
          done_d = 1'b1;
          if (free_ok) begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q & ~free_onehot;
            free_d    = free_q + COUNT_W'(1);
            rsp_d     = '{status: STATUS_OK, result_index: '0};
          end else begin
            rsp_d     = '{status: STATUS_BAD_FREE, result_index: '0};
          end
        end else if (found) begin
          done_d    = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = rdata_q | (8'h01 << bit_sel);
          free_d    = free_q - COUNT_W'(1);
          search_d  = addr_q;
          rsp_d     = '{status: STATUS_OK, result_index: INDEX_W'({addr_q, bit_sel})};
        end else if (scan_end) begin
          done_d = 1'b1;
          rsp_d  = '{status: STATUS_EXHAUSTED, result_index: '0};
        end else begin
          addr_d = next_byte;
          scan_d = scan_q + NB_W'(1);
        end
      end
      default: begin
      end
    endcase
    // A count write restarts the allocator with a clearing pass.
    if (cfg_we_i) begin
      usable_d = usable_of(cfg_wdata_i);
      free_d   = usable_of(cfg_wdata_i);
      search_d = '0;
      addr_d   = '0;
      done_d   = 1'b0;
      mem_we   = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      usable_q <= USABLE_RST;
      free_q   <= USABLE_RST;
      search_q <= '0;
      addr_q   <= '0;
      scan_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      usable_q <= usable_d;
      free_q   <= free_d;
      search_q <= search_d;
      addr_q   <= addr_d;
      scan_q   <= scan_d;
      done_q   <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    rsp_q <= rsp_d;
  end

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[addr_q] <= mem_wdata;
    end
    rdata_q <= bitmap_q[addr_q];
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- rtl/pfba_checker.sv -----
// ----------------------------------------------------------------------------
// Page frame bitmap allocator checker
// Port-level assertions on request and result transfers, bound to the top.
// ----------------------------------------------------------------------------
module pfba_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          done_o,
  input  pfba_pkg::pfba_rsp_t           rsp_o
);
  import pfba_pkg::*;

  // An accepted request either keeps the unit busy or completes at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !cfg_we_i |=> busy || done_o)
    else $error("accepted request neither busy nor completed");

  // A result transfer is only shown when the unit is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.status == STATUS_OK || rsp_o.status == STATUS_EXHAUSTED ||
               rsp_o.status == STATUS_BAD_FREE)
    else $error("undefined status code");

  // A failed request returns a zero index.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != STATUS_OK |-> rsp_o.result_index == '0)
    else $error("non-zero index on failure");

  // The unit is busy with its clearing pass straight after a count write.
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy && !done_o)
    else $error("count write did not start a clearing pass");

endmodule

bind page_frame_bitmap_allocator_unit pfba_checker u_pfba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .rsp_o       (rsp_o)
);

// ----- tb/page_frame_bitmap_allocator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page frame bitmap allocator testbench
// Sends allocate and free requests through the start/busy handshake and
// checks every done strobe against a next-fit bitmap predictor kept in a
// small scoreboard class. The frame count register is reprogrammed between
// phases, covering the smallest, largest, zero and over-range settings.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_unit_tb;
  import pfba_pkg::*;

  localparam int unsigned MAP_BYTES   = NUM_FRAMES_DEF / 8;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASE_ITEMS = 55;

  // Predicts allocator replies and holds the ones still to arrive.
  class allocation_tracker;
    logic [7:0]         used_map [MAP_BYTES];
    int unsigned        frames_free;
    int unsigned        next_byte;
    logic [COUNT_W-1:0] count_reg;
    pfba_rsp_t          awaited_replies [$];
    int unsigned        failures;

    function new();
      failures = 0;
      set_frame_count(FRAME_COUNT_RST);
    endfunction

    // Usable frames: the register value capped at the bitmap size.
    function int unsigned usable();
      return (count_reg > NUM_FRAMES_DEF) ? NUM_FRAMES_DEF : int'(count_reg);
    endfunction

    // A register write restarts the allocator with an empty bitmap.
    function void set_frame_count(logic [COUNT_W-1:0] value);
      count_reg = value;
      foreach (used_map[k]) used_map[k] = '0;
      frames_free = usable();
      next_byte   = 0;
    endfunction

    // Bits of byte k that stand for usable frames.
    function logic [7:0] byte_mask(int unsigned k, int unsigned cnt);
      int unsigned first;
      first = k * 8;
      if (first >= cnt) return 8'h00;
      if (cnt - first >= 8) return 8'hFF;
      return 8'((1 << (cnt - first)) - 1);
    endfunction

    // Works out the reply to an accepted request and updates the bitmap.
    function void note_request(pfba_req_t req);
      pfba_rsp_t   reply;
      int unsigned cnt, nbytes, k, b, n;
      logic [7:0]  avail;
      bit          found;
      cnt                = usable();
      reply.status       = STATUS_OK;
      reply.result_index = '0;
      found              = 1'b0;
      if (req.cmd == CMD_ALLOC) begin
        nbytes = (cnt + 7) / 8;
        if (frames_free != 0 && nbytes != 0) begin
          k = (next_byte < nbytes) ? next_byte : 0;
          for (n = 0; n < nbytes && !found; n++) begin
            avail = ~used_map[k] & byte_mask(k, cnt);
            if (avail != 0) begin
              b = 0;
              while (!avail[b]) b++;
              used_map[k][b]     = 1'b1;
              frames_free        = frames_free - 1;
              next_byte          = k;
              reply.result_index = INDEX_W'(k * 8 + b);
              found              = 1'b1;
            end else begin
              k = (k + 1 >= nbytes) ? 0 : k + 1;
            end
          end
        end
        if (!found) reply.status = STATUS_EXHAUSTED;
      end else begin
        if (req.frame_index >= cnt || !used_map[req.frame_index / 8][req.frame_index % 8]) begin
          reply.status = STATUS_BAD_FREE;
        end else begin
          used_map[req.frame_index / 8][req.frame_index % 8] = 1'b0;
          frames_free = (frames_free + 1) & 32'h1FFF;
        end
      end
      awaited_replies.push_back(reply);
    endfunction

    // Compares a reply with the oldest prediction.
    function void check_result(pfba_rsp_t got);
      pfba_rsp_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply, status %0d index %0d", $time, got.status,
                 got.result_index);
        failures++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status || got.result_index !== want.result_index) begin
        $display("%0t: expected status %0d index %0d, actual status %0d index %0d", $time,
                 want.status, want.result_index, got.status, got.result_index);
        failures++;
      end
    endfunction

    // A frame currently in use, or any index when none is.
    function logic [INDEX_W-1:0] pick_used();
      int unsigned cnt, start_at, idx, i;
      cnt = usable();
      if (cnt != 0 && frames_free != cnt) begin
        start_at = $urandom_range(cnt - 1);
        for (i = 0; i < cnt; i++) begin
          idx = (start_at + i) % cnt;
          if (used_map[idx / 8][idx % 8]) return INDEX_W'(idx);
        end
      end
      return INDEX_W'($urandom_range(NUM_FRAMES_DEF - 1));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;
  logic               start;
  pfba_req_t          req_i;
  logic               busy;
  logic               done_o;
  pfba_rsp_t          rsp_o;

  allocation_tracker  tracker;
  bit                 steady;
  int unsigned        idle_cycles = 0;

  page_frame_bitmap_allocator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Observe every transfer at the clock edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_result(rsp_o);
      if (cfg_we_i) tracker.set_frame_count(cfg_wdata_i);
      if (start && !busy) tracker.note_request(req_i);
    end
  end

  // End the run if no transfer happens for too long.
  always @(posedge clk_i) begin
    if (done_o === 1'b1 || cfg_we_i || (start && busy === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("page_frame_bitmap_allocator_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Random pause before a request; none in steady stretches.
  task automatic idle_gap();
    int unsigned roll, gap;
    roll = $urandom_range(99);
    if (steady || roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Present one request and hold it until the block takes it.
  task automatic issue(logic cmd, logic [INDEX_W-1:0] idx);
    idle_gap();
    start             <= 1'b1;
    req_i.cmd         <= cmd;
    req_i.frame_index <= idx;
    do @(posedge clk_i); while (busy);
  endtask

  // Wait until every predicted reply has arrived.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.awaited_replies.size() != 0);
  endtask

  // Write the frame count once the block is idle.
  task automatic reprogram(logic [COUNT_W-1:0] value);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  // Mostly allocations and frees of frames in use, with stray frees as noise.
  task automatic random_phase(int unsigned items);
    int unsigned alloc_pct, roll, i;
    alloc_pct = $urandom_range(80, 40);
    steady    = ($urandom_range(3) == 0);
    for (i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      if (roll < alloc_pct) issue(CMD_ALLOC, INDEX_W'($urandom()));
      else if (roll < 92) issue(CMD_FREE, tracker.pick_used());
      else issue(CMD_FREE, INDEX_W'($urandom()));
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] settings [13];
    int unsigned        p;
    settings = '{13'd1, 13'd8, 13'd9, 13'd17, 13'd24, 13'd64, 13'd100, 13'd0,
                 13'd8191, 13'd4095, 13'd37, 13'd4097, 13'd4096};
    tracker     = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = FRAME_COUNT_RST;
    start       = 1'b0;
    req_i       = '0;
    steady      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full bitmap after reset: simple allocations, a double free and a free
    // of a frame that was never handed out.
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '1);
    issue(CMD_FREE, '0);
    issue(CMD_FREE, '0);
    issue(CMD_FREE, '1);
    issue(CMD_ALLOC, '0);

    // Nine frames: the last byte has one usable bit, then exhaustion,
    // a free past the count and reuse of a freed frame.
    reprogram(13'd9);
    repeat (9) issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, 12'd9);
    issue(CMD_FREE, 12'd8);
    issue(CMD_ALLOC, '0);

    // No usable frames at all.
    reprogram(13'd0);
    issue(CMD_ALLOC, '0);
    issue(CMD_FREE, '0);

    // Count above the bitmap size is capped.
    reprogram(13'd8191);
    issue(CMD_ALLOC, '1);
    issue(CMD_FREE, '1);

    // Random phases over a spread of frame counts.
    reprogram(FRAME_COUNT_RST);
    random_phase(PHASE_ITEMS);
    for (p = 0; p < 13; p++) begin
      reprogram(settings[p]);
      random_phase(PHASE_ITEMS);
    end
    reprogram(COUNT_W'($urandom_range(4096, 1)));
    random_phase(PHASE_ITEMS);

    drain();
    repeat (20) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("page_frame_bitmap_allocator_unit: match");
    end else begin
      $display("page_frame_bitmap_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
